@@ src/brbpc_pkg.sv @@
// brbpc_pkg: shared types and constants for the byte ring buffer with peek
// used by brbpc_front, brbpc_cmd_q, brbpc_back and the top level
// no dependencies
package brbpc_pkg;

  localparam int CW  = 11;  // capacity, size, fill and position width
  localparam int DW  = 8;   // byte width
  localparam int IW  = 10;  // byte index and peek offset width
  localparam int SW  = 13;  // width of three-operand position sums
  localparam int KW  = 7;   // peek beat counter width
  localparam int QD  = 2;   // command queue depth
  localparam int QAW = 1;
  localparam int OD  = 2;   // result queue depth
  localparam int OAW = 1;

  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    K_WRITE   = 2'd0,
    K_CANCEL  = 2'd1,
    K_PEEK    = 2'd2,
    K_CONSUME = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_PENDING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_RES  = 2'd0,
    OP_WR   = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [CW-1:0]   addr;
    logic [DW-1:0]   data;
    status_e         status;
    logic [CW-1:0]   count;
    logic [CW-1:0]   used;
    logic [CW-1:0]   left;
  } cmd_t;

  typedef struct packed {
    status_e         status;
    logic [CW-1:0]   count;
    logic [DW-1:0]   data;
    logic            dvalid;
    logic            last;
    logic [CW-1:0]   used;
    logic [CW-1:0]   left;
  } res_t;

endpackage

@@ src/brbpc_front.sv @@
// brbpc_front: config register, head/fill/chunk state and item classification
// emits one command per accepted item into the command queue
// depends on brbpc_pkg
module brbpc_front import brbpc_pkg::*; #(
  parameter int DEPTH    = 1024,
  parameter int MAX_READ = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    kind_i,
  input  logic [DW-1:0] data_byte_i,
  input  logic [CW-1:0] chunk_size_i,
  input  logic [IW-1:0] byte_index_i,
  input  logic [IW-1:0] peek_offset_i,
  input  logic          busy_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output cmd_t          q_cmd_o,
  output logic [CW-1:0] cap_o
);

  localparam logic [CW-1:0] CapRst = CW'((DEPTH < 1024) ? DEPTH : 1024);

  logic [CW-1:0] cap_q, head_q, head_d, fill_q, fill_d;
  logic          chunk_q, chunk_d;
  logic          cfg_we, accept;
  logic [CW-1:0] cap_wr, freeb, size;
  logic [SW-1:0] wsum, psum, csum;
  logic [CW-1:0] wpos, ppos, cpos;
  cmd_t          cmd;

  function automatic logic [CW-1:0] wrap(input logic [SW-1:0] s, input logic [CW-1:0] c);
    logic [SW-1:0] r;
    r = (s >= SW'(c)) ? s - SW'(c) : s;
    return r[CW-1:0];
  endfunction

  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CW){1'b0}}, cap_q} : 32'd0;

  always_comb begin
    if (pwdata[CW-1:0] == '0) begin
      cap_wr = CW'(1);
    end else if (32'(pwdata[CW-1:0]) > 32'(DEPTH)) begin
      cap_wr = CW'(DEPTH);
    end else begin
      cap_wr = pwdata[CW-1:0];
    end
  end

  assign in_ready_o = !busy_i && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign size       = chunk_size_i;
  assign freeb      = cap_q - fill_q;

  assign wsum = SW'(head_q) + SW'(fill_q) + SW'(byte_index_i);
  assign psum = SW'(head_q) + SW'(peek_offset_i);
  assign csum = SW'(head_q) + SW'(size);
  assign wpos = wrap(wsum, cap_q);
  assign ppos = wrap(psum, cap_q);
  assign cpos = wrap(csum, cap_q);

  always_comb begin
    head_d     = head_q;
    fill_d     = fill_q;
    chunk_d    = chunk_q;
    cmd.op     = OP_RES;
    cmd.addr   = '0;
    cmd.data   = data_byte_i;
    cmd.status = ST_REFUSED;
    cmd.count  = '0;
    case (kind_e'(kind_i))
      K_WRITE: begin
        if (byte_index_i == '0 && size == '0) begin
          chunk_d    = 1'b0;
          cmd.status = ST_OK;
        end else if ((byte_index_i == '0 || chunk_q) && CW'(byte_index_i) < size
                     && size <= freeb) begin
          cmd.op   = OP_WR;
          cmd.addr = wpos;
          if (CW'(byte_index_i) + CW'(1) == size) begin
            fill_d     = fill_q + size;
            chunk_d    = 1'b0;
            cmd.status = ST_OK;
            cmd.count  = size;
          end else begin
            chunk_d    = 1'b1;
            cmd.status = ST_PENDING;
          end
        end else begin
          chunk_d = 1'b0;
        end
      end
      K_CANCEL: begin
        chunk_d = 1'b0;
        if (size <= fill_q) begin
          fill_d     = fill_q - size;
          cmd.status = ST_OK;
          cmd.count  = size;
        end
      end
      K_PEEK: begin
        if (size <= CW'(MAX_READ) && (SW'(peek_offset_i) + SW'(size)) <= SW'(fill_q)) begin
          cmd.status = ST_OK;
          cmd.count  = size;
          if (size != '0) begin
            cmd.op   = OP_PEEK;
            cmd.addr = ppos;
          end
        end
      end
      K_CONSUME: begin
        if (size <= fill_q) begin
          head_d     = cpos;
          fill_d     = fill_q - size;
          cmd.status = ST_OK;
          cmd.count  = size;
        end
      end
      default: begin
        chunk_d = chunk_q;
      end
    endcase
    cmd.used = fill_d;
    cmd.left = cap_q - fill_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CapRst;
      head_q  <= '0;
      fill_q  <= '0;
      chunk_q <= 1'b0;
    end else if (cfg_we) begin
      cap_q   <= cap_wr;
      head_q  <= '0;
      fill_q  <= '0;
      chunk_q <= 1'b0;
    end else if (accept) begin
      head_q  <= head_d;
      fill_q  <= fill_d;
      chunk_q <= chunk_d;
    end
  end

  assign q_push_o = accept;
  assign q_cmd_o  = cmd;
  assign cap_o    = cap_q;

endmodule

@@ src/brbpc_cmd_q.sv @@
// brbpc_cmd_q: short command queue between front and back
// depends on brbpc_pkg
module brbpc_cmd_q import brbpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t            mem_q [QD];
  logic [QAW-1:0]  wptr_q, rptr_q;
  logic [QAW:0]    cnt_q;

  assign full_o  = (cnt_q == (QAW+1)'(QD));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QAW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QAW'(1);
      end
      cnt_q <= cnt_q + (QAW+1)'(push_i) - (QAW+1)'(pop_i);
    end
  end

endmodule

@@ src/brbpc_back.sv @@
// brbpc_back: byte store, clearing sweep, command execution and result queue
// depends on brbpc_pkg
module brbpc_back import brbpc_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [CW-1:0] cap_i,
  input  logic          cmd_valid_i,
  input  cmd_t          cmd_i,
  output logic          cmd_pop_o,
  output logic          busy_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output res_t          out_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = ((AW > CW) ? AW : CW) + 1;

  logic [DW-1:0]  mem_q [DEPTH];
  logic [DW-1:0]  rd_data_q;
  logic           clr_q;
  logic [AW-1:0]  clr_addr_q;
  logic [KW-1:0]  k_q, k_d;
  logic [AW-1:0]  ptr_q, ptr_d, rd_addr, wr_addr;
  logic [DW-1:0]  wr_data;
  logic           we, issue, peek_last;
  logic           s2_valid_q, s2_rd_q, s2_rd_d;
  res_t           s2_q, s2_d;
  res_t           ofq_q [OD];
  logic [OAW-1:0] owptr_q, orptr_q;
  logic [OAW:0]   ocnt_q;
  logic           pop;
  logic [2:0]     occ;
  res_t           push_res;

  assign busy_o      = clr_q;
  assign out_valid_o = (ocnt_q != '0);
  assign out_o       = ofq_q[orptr_q];
  assign pop         = out_valid_o && out_ready_i;

  assign occ   = 3'(ocnt_q) + 3'(s2_valid_q) - 3'(pop);
  assign issue = !clr_q && cmd_valid_i && (occ <= 3'd1);

  assign rd_addr   = (k_q == '0) ? AW'(cmd_i.addr) : ptr_q;
  assign peek_last = (CW'(k_q) + CW'(1) == cmd_i.count);

  always_comb begin
    ptr_d     = ((PW'(rd_addr) + PW'(1)) == PW'(cap_i)) ? '0 : rd_addr + AW'(1);
    k_d       = k_q;
    cmd_pop_o = 1'b0;
    we        = clr_q;
    wr_addr   = clr_addr_q;
    wr_data   = '0;
    s2_rd_d   = 1'b0;
    s2_d.status = cmd_i.status;
    s2_d.count  = cmd_i.count;
    s2_d.data   = '0;
    s2_d.dvalid = 1'b0;
    s2_d.last   = 1'b1;
    s2_d.used   = cmd_i.used;
    s2_d.left   = cmd_i.left;
    if (issue) begin
      case (cmd_i.op)
        OP_WR: begin
          we        = 1'b1;
          wr_addr   = AW'(cmd_i.addr);
          wr_data   = cmd_i.data;
          cmd_pop_o = 1'b1;
        end
        OP_PEEK: begin
          s2_rd_d   = 1'b1;
          s2_d.last = peek_last;
          if (peek_last) begin
            k_d       = '0;
            cmd_pop_o = 1'b1;
          end else begin
            k_d = k_q + KW'(1);
          end
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    push_res        = s2_q;
    push_res.dvalid = s2_rd_q;
    push_res.data   = s2_rd_q ? rd_data_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_q    <= s2_d;
      s2_rd_q <= s2_rd_d;
    end
    if (issue && cmd_i.op == OP_PEEK) begin
      ptr_q <= ptr_d;
    end
    if (s2_valid_q) begin
      ofq_q[owptr_q] <= push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      k_q        <= '0;
      s2_valid_q <= 1'b0;
      owptr_q    <= '0;
      orptr_q    <= '0;
      ocnt_q     <= '0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
      k_q        <= k_d;
      s2_valid_q <= issue;
      if (s2_valid_q) begin
        owptr_q <= owptr_q + OAW'(1);
      end
      if (pop) begin
        orptr_q <= orptr_q + OAW'(1);
      end
      ocnt_q <= ocnt_q + (OAW+1)'(s2_valid_q) - (OAW+1)'(pop);
    end
  end

endmodule

@@ src/byte_ring_buffer_peek_consume_core.sv @@
// byte_ring_buffer_peek_consume_core: top level of the circular byte fifo with peek
// instantiates brbpc_front, brbpc_cmd_q and brbpc_back; depends on brbpc_pkg
//
// input channel: one beat per item (write byte, cancel, peek, consume) on
// in_valid_i/in_ready_o; output channel: result beats on out_valid_o/out_ready_i.
// a write, cancel or consume gives one result beat, a peek of n bytes gives n
// beats (last_o on the final one), a refused or empty peek gives one.
// the front takes one item per cycle while in_ready_o is high and updates head
// and fill at once; the back runs one memory access per cycle while the result
// queue has room, so a peek of n bytes holds the back for n reads. an input beat
// passes the command queue, result stage register and result queue to the output.
// capacity is set through the apb port at byte address 0 and resets to 1024
// (or DEPTH if smaller); a capacity write empties the buffer.
// after reset the back zeroes all DEPTH bytes of the store one byte a cycle, with
// in_ready_o low; the apb port works during that sweep.
// when the receiver stalls, two result beats and two commands are buffered
// before in_ready_o drops.
module byte_ring_buffer_peek_consume_core import brbpc_pkg::*; #(
  parameter int DEPTH    = 1024,
  parameter int MAX_READ = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    kind_i,
  input  logic [DW-1:0] data_byte_i,
  input  logic [CW-1:0] chunk_size_i,
  input  logic [IW-1:0] byte_index_i,
  input  logic [IW-1:0] peek_offset_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    status_o,
  output logic [CW-1:0] count_o,
  output logic [DW-1:0] data_out_o,
  output logic          data_valid_o,
  output logic          last_o,
  output logic [CW-1:0] used_o,
  output logic [CW-1:0] left_o
);

  logic          busy, q_full, q_push, q_valid, q_pop;
  cmd_t          q_in, q_out;
  logic [CW-1:0] cap;
  res_t          res;

  assign pready = 1'b1;

  brbpc_front #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .data_byte_i   (data_byte_i),
    .chunk_size_i  (chunk_size_i),
    .byte_index_i  (byte_index_i),
    .peek_offset_i (peek_offset_i),
    .busy_i        (busy),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_in),
    .cap_o         (cap)
  );

  brbpc_cmd_q u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_out)
  );

  brbpc_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_out),
    .cmd_pop_o   (q_pop),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign status_o     = res.status;
  assign count_o      = res.count;
  assign data_out_o   = res.data;
  assign data_valid_o = res.dvalid;
  assign last_o       = res.last;
  assign used_o       = res.used;
  assign left_o       = res.left;

endmodule

@@ src/brbpc_chk.sv @@
// brbpc_chk: port-level checks on the result channel of the top level
// bound to byte_ring_buffer_peek_consume_core; depends on brbpc_pkg
module brbpc_chk import brbpc_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input logic [1:0]    status_o,
  input logic [CW-1:0] count_o,
  input logic [DW-1:0] data_out_o,
  input logic          data_valid_o,
  input logic          last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_out_o) && $stable(last_o))
    else $error("result beat dropped or changed while stalled");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !data_valid_o |-> last_o && data_out_o == '0)
    else $error("non-data result must be single with zero data");

  a_peek_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_valid_o |-> status_o == ST_OK && count_o != '0)
    else $error("peek data beat with bad status or count");

  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_PENDING || status_o == ST_REFUSED) |-> count_o == '0)
    else $error("uncommitted or refused result with nonzero count");

endmodule

bind byte_ring_buffer_peek_consume_core brbpc_chk u_brbpc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .count_o      (count_o),
  .data_out_o   (data_out_o),
  .data_valid_o (data_valid_o),
  .last_o       (last_o)
);

@@ tb/tb_byte_ring_buffer_peek_consume_core.sv @@
// tb_byte_ring_buffer_peek_consume_core: self-checking bench for the byte ring buffer with peek
// drives write/cancel/peek/consume beats and apb capacity writes, checks every result beat
// against a shadow copy of the store; depends on brbpc_pkg and byte_ring_buffer_peek_consume_core
module tb_byte_ring_buffer_peek_consume_core;
  import brbpc_pkg::*;

  localparam int DEPTH  = 1024;
  localparam int MAX_RD = 64;
  localparam logic [2:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct packed {
    kind_e         kind;
    logic [DW-1:0] data;
    logic [CW-1:0] size;
    logic [IW-1:0] idx;
    logic [IW-1:0] off;
  } req_t;

  logic          clk_i;
  logic          rst_ni        = 1'b0;
  logic          psel          = 1'b0;
  logic          penable       = 1'b0;
  logic          pwrite        = 1'b0;
  logic [2:0]    paddr         = '0;
  logic [31:0]   pwdata        = '0;
  logic [31:0]   prdata;
  logic          pready;
  logic          in_valid_i    = 1'b0;
  logic          in_ready_o;
  logic [1:0]    kind_i        = '0;
  logic [DW-1:0] data_byte_i   = '0;
  logic [CW-1:0] chunk_size_i  = '0;
  logic [IW-1:0] byte_index_i  = '0;
  logic [IW-1:0] peek_offset_i = '0;
  logic          out_valid_o;
  logic          out_ready_i   = 1'b0;
  logic [1:0]    status_o;
  logic [CW-1:0] count_o;
  logic [DW-1:0] data_out_o;
  logic          data_valid_o;
  logic          last_o;
  logic [CW-1:0] used_o;
  logic [CW-1:0] left_o;

  byte_ring_buffer_peek_consume_core #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_RD)
  ) dut (.*);

  logic [DW-1:0] shadow_mem [DEPTH];
  int            shadow_head;
  int            shadow_fill;
  int            shadow_cap;
  bit            chunk_open;

  req_t req_queue [$];
  res_t due_results [$];
  int   issued = 0;
  int   errors = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  bit   in_fire = 1'b0;
  bit   calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int lesser(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic void push_result(status_e st, int cnt, int d, bit dv, bit lst);
    res_t r;
    r.status = st;
    r.count  = CW'(cnt);
    r.data   = DW'(d);
    r.dvalid = dv;
    r.last   = lst;
    r.used   = CW'(shadow_fill);
    r.left   = CW'(shadow_cap - shadow_fill);
    due_results.push_back(r);
  endfunction

  function automatic void ring_config(logic [31:0] v);
    int c;
    c = int'(v[CW-1:0]);
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    shadow_cap  = c;
    shadow_head = 0;
    shadow_fill = 0;
    chunk_open  = 1'b0;
  endfunction

  function automatic void ring_apply(req_t r);
    int sz, ix, of, freeb;
    sz = int'(r.size);
    ix = int'(r.idx);
    of = int'(r.off);
    freeb = shadow_cap - shadow_fill;
    case (r.kind)
      K_WRITE: begin
        if (ix == 0 && sz == 0) begin
          chunk_open = 1'b0;
          push_result(ST_OK, 0, 0, 1'b0, 1'b1);
        end else if ((ix == 0 || chunk_open) && ix < sz && sz <= freeb) begin
          shadow_mem[(shadow_head + shadow_fill + ix) % shadow_cap] = r.data;
          if (ix + 1 == sz) begin
            shadow_fill += sz;
            chunk_open = 1'b0;
            push_result(ST_OK, sz, 0, 1'b0, 1'b1);
          end else begin
            chunk_open = 1'b1;
            push_result(ST_PENDING, 0, 0, 1'b0, 1'b1);
          end
        end else begin
          chunk_open = 1'b0;
          push_result(ST_REFUSED, 0, 0, 1'b0, 1'b1);
        end
      end
      K_CANCEL: begin
        chunk_open = 1'b0;
        if (sz <= shadow_fill) begin
          shadow_fill -= sz;
          push_result(ST_OK, sz, 0, 1'b0, 1'b1);
        end else begin
          push_result(ST_REFUSED, 0, 0, 1'b0, 1'b1);
        end
      end
      K_PEEK: begin
        if (sz > MAX_RD || of + sz > shadow_fill) begin
          push_result(ST_REFUSED, 0, 0, 1'b0, 1'b1);
        end else if (sz == 0) begin
          push_result(ST_OK, 0, 0, 1'b0, 1'b1);
        end else begin
          for (int k = 0; k < sz; k++) begin
            push_result(ST_OK, sz, shadow_mem[(shadow_head + of + k) % shadow_cap], 1'b1,
                        k + 1 == sz);
          end
        end
      end
      default: begin
        if (sz <= shadow_fill) begin
          shadow_head = (shadow_head + sz) % shadow_cap;
          shadow_fill -= sz;
          push_result(ST_OK, sz, 0, 1'b0, 1'b1);
        end else begin
          push_result(ST_REFUSED, 0, 0, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic void issue(kind_e k, int d, int sz, int ix, int of);
    req_t r;
    r.kind = k;
    r.data = DW'(d);
    r.size = CW'(sz);
    r.idx  = IW'(ix);
    r.off  = IW'(of);
    ring_apply(r);
    req_queue.push_back(r);
    issued++;
  endfunction

  function automatic void gen_random(int n);
    int start, pick, freeb, sz, of, stop;
    start = issued;
    while (issued - start < n) begin
      pick  = $urandom_range(0, 99);
      freeb = shadow_cap - shadow_fill;
      if (pick < 45) begin
        pick = $urandom_range(0, 99);
        if (freeb == 0 || pick < 8) sz = freeb + $urandom_range(1, 8);
        else if (pick < 20) sz = $urandom_range(1, lesser(freeb, 80));
        else sz = $urandom_range(1, lesser(freeb, 12));
        stop = (sz > freeb) ? lesser(sz, 3) : sz;
        if ($urandom_range(0, 9) == 0) stop = $urandom_range(0, stop - 1);
        for (int i = 0; i < stop; i++) begin
          if (i > 0 && $urandom_range(0, 59) == 0) begin
            issue(K_WRITE, $urandom_range(0, 255), sz, $urandom_range(0, 1023),
                  $urandom_range(0, 1023));
          end else begin
            issue(K_WRITE, $urandom_range(0, 255), sz, i, $urandom_range(0, 1023));
          end
        end
      end else if (pick < 68) begin
        if (shadow_fill > 0 && $urandom_range(0, 6) != 0) begin
          sz = $urandom_range(0, lesser(MAX_RD, shadow_fill));
          of = $urandom_range(0, lesser(shadow_fill - sz, 1023));
        end else begin
          sz = ($urandom_range(0, 1) == 0) ? MAX_RD + 1 : $urandom_range(0, 2047);
          of = $urandom_range(0, 1023);
        end
        issue(K_PEEK, $urandom_range(0, 255), sz, $urandom_range(0, 1023), of);
      end else if (pick < 82) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                         : $urandom_range(0, shadow_fill);
        issue(K_CONSUME, $urandom_range(0, 255), sz, $urandom_range(0, 1023),
              $urandom_range(0, 1023));
      end else if (pick < 95) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                         : $urandom_range(0, lesser(shadow_fill, 8));
        issue(K_CANCEL, $urandom_range(0, 255), sz, $urandom_range(0, 1023),
              $urandom_range(0, 1023));
      end else begin
        issue(kind_e'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom_range(0, 2047),
              $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
    end
  endfunction

  task automatic wait_idle();
    while (req_queue.size() != 0 || due_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [31:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ring_config(v);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(negedge clk_i) begin : drv
    req_t nxt;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (req_queue.size() != 0 && !calm && $urandom_range(0, 13) == 0) begin
        in_gap <= $urandom_range(0, 18);
        in_valid_i <= 1'b0;
      end else if (req_queue.size() != 0) begin
        nxt = req_queue.pop_front();
        in_valid_i    <= 1'b1;
        kind_i        <= nxt.kind;
        data_byte_i   <= nxt.data;
        chunk_size_i  <= nxt.size;
        byte_index_i  <= nxt.idx;
        peek_offset_i <= nxt.off;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_gap <= $urandom_range(0, 18);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : mon
    res_t want;
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual status %0d count %0d",
                 $time, status_o, count_o);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("count", 32'(want.count), 32'(count_o));
        check_field("data_out", 32'(want.data), 32'(data_out_o));
        check_field("data_valid", 32'(want.dvalid), 32'(data_valid_o));
        check_field("last", 32'(want.last), 32'(last_o));
        check_field("used", 32'(want.used), 32'(used_o));
        check_field("left", 32'(want.left), 32'(left_o));
      end
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) shadow_mem[i] = '0;
    ring_config(32'd1024);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // short directed pass at the reset capacity
    issue(K_WRITE, 8'hFF, 0, 0, 0);
    issue(K_PEEK, 0, 0, 0, 0);
    issue(K_CONSUME, 0, 1, 0, 0);
    issue(K_WRITE, 8'h00, 4, 0, 1023);
    issue(K_WRITE, 8'hFF, 4, 1, 1023);
    issue(K_WRITE, 8'hA5, 4, 2, 1023);
    issue(K_WRITE, 8'h5A, 4, 3, 1023);
    issue(K_WRITE, 8'h3C, 4, 1, 0);
    issue(K_WRITE, 8'hFF, 2047, 0, 0);
    issue(K_PEEK, 0, 4, 0, 0);
    issue(K_PEEK, 0, MAX_RD + 1, 0, 0);
    issue(K_PEEK, 0, 1, 0, 1023);
    issue(K_WRITE, 8'h11, 3, 0, 0);
    issue(K_WRITE, 8'h22, 3, 1, 0);
    issue(K_WRITE, 8'h33, 2, 0, 0);
    issue(K_WRITE, 8'h44, 2, 1, 0);
    issue(K_WRITE, 8'h55, 3, 0, 0);
    issue(K_CANCEL, 0, 2047, 0, 0);
    issue(K_WRITE, 8'h66, 3, 1, 0);
    issue(K_CANCEL, 0, 1, 0, 0);
    issue(K_CONSUME, 0, 2, 0, 0);
    issue(K_WRITE, 8'h77, 3, 5, 0);
    issue(K_WRITE, 8'h88, 2, 0, 0);
    issue(K_CONSUME, 0, 2047, 0, 0);
    issue(K_WRITE, 8'h99, 2, 1, 0);
    issue(K_PEEK, 0, 5, 0, 0);
    wait_idle();

    cfg_write(32'd1024);
    gen_random(50);
    wait_idle();
    gen_random(45);
    wait_idle();
    cfg_write(32'd0);
    gen_random(40);
    wait_idle();
    cfg_write(32'h0000_F825);
    gen_random(90);
    wait_idle();
    cfg_write(32'd2047);
    gen_random(50);
    wait_idle();
    calm = 1'b1;
    cfg_write(32'd100);
    gen_random(70);
    wait_idle();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
